>>> hw/rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted address floor search package
// Field widths, command codes and the token that walks the search cells.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Fixed field widths of the channels and the count register.
  localparam int unsigned CMD_W  = 1;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned CNT_W  = 11;

  // Command codes of an input word.
  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

  // Best match found so far.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] offset;
  } sfs_hit_t;

  // Control part of the search token handed from cell to cell.
  // sel_a tells which table read port holds the probe of the next cell.
  typedef struct packed {
    logic     valid;
    logic     sel_a;
    sfs_hit_t hit;
  } sfs_tok_t;

endpackage

>>> hw/rtl/sfs_intf.sv
// ----------------------------------------------------------------------------
// Sorted address floor search channels
// Valid/ready interfaces for the command input, the result output and the
// count register write port.
// ----------------------------------------------------------------------------

// Command word: table write or lookup.
interface sfs_in_if
  import sfs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  entry_index;
  logic [ADDR_W-1:0] entry_address;
  logic [ADDR_W-1:0] query_address;

  modport source (
    output valid, command, entry_index, entry_address, query_address,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_address, query_address,
    output ready
  );
endinterface

// Result word of a lookup.
interface sfs_out_if
  import sfs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              found;
  logic [IDX_W-1:0]  symbol_index;
  logic [ADDR_W-1:0] offset;

  modport source (
    output valid, found, symbol_index, offset,
    input  ready
  );
  modport sink (
    input  valid, found, symbol_index, offset,
    output ready
  );
endinterface

// Count register write port.
interface sfs_cfg_if
  import sfs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] symbol_count;

  modport source (
    output valid, symbol_count,
    input  ready
  );
  modport sink (
    input  valid, symbol_count,
    output ready
  );
endinterface

>>> hw/rtl/sfs_table.sv
// ----------------------------------------------------------------------------
// Address table
// One write port and two registered read ports over the start addresses.
// ----------------------------------------------------------------------------
module sfs_table
  import sfs_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [ADDR_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output logic [ADDR_W-1:0] rdata_a_o,
  output logic [ADDR_W-1:0] rdata_b_o
);

  logic [ADDR_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Both read ports are registered: the data follows in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> hw/rtl/sfs_cell.sv
// ----------------------------------------------------------------------------
// Search cell
// Holds one step of the binary search: the window, the best match so far
// and which read port carries its probe. Compares, narrows the window and
// hands the token to the next cell while reading both possible next probes.
// ----------------------------------------------------------------------------
module sfs_cell
  import sfs_pkg::*;
#(
  parameter int unsigned AW = 10,
  parameter int unsigned CW = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfs_tok_t          prev_tok_i,
  input  logic [CW-1:0]     prev_lo_i,
  input  logic [CW-1:0]     prev_end_i,
  input  logic [AW-1:0]     prev_idx_i,
  input  logic [ADDR_W-1:0] query_i,
  input  logic [ADDR_W-1:0] rdata_a_i,
  input  logic [ADDR_W-1:0] rdata_b_i,
  output sfs_tok_t          nxt_tok_o,
  output logic [CW-1:0]     nxt_lo_o,
  output logic [CW-1:0]     nxt_end_o,
  output logic [AW-1:0]     nxt_idx_o,
  output logic              active_o,
  output logic              done_o,
  output logic [AW-1:0]     raddr_a_o,
  output logic [AW-1:0]     raddr_b_o
);

  logic              valid_q;
  logic              sel_a_q;
  logic              found_q;
  logic [ADDR_W-1:0] off_q;
  logic [CW-1:0]     lo_q;
  logic [CW-1:0]     end_q;
  logic [AW-1:0]     idx_q;

  logic [ADDR_W-1:0] probe;
  logic [ADDR_W:0]   diff;
  logic              hit;
  logic [CW:0]       sum_mid;
  logic [CW-1:0]     mid;
  logic [CW:0]       sum_a;
  logic [CW:0]       sum_b;
  logic [CW-1:0]     mid_a;
  logic [CW-1:0]     mid_b;
  logic              new_empty;

  // The token valid bit is the only state of a cell that is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= prev_tok_i.valid;
    end
  end

  // Window and match payload follow the valid bit.
  always_ff @(posedge clk_i) begin
    sel_a_q <= prev_tok_i.sel_a;
    found_q <= prev_tok_i.hit.found;
    off_q   <= prev_tok_i.hit.offset;
    lo_q    <= prev_lo_i;
    end_q   <= prev_end_i;
    idx_q   <= prev_idx_i;
  end

  // Probe compare: the subtraction gives both the floor test and the offset.
  always_comb begin
    probe = sel_a_q ? rdata_a_i : rdata_b_i;
    diff  = {1'b0, query_i} - {1'b0, probe};
    hit   = ~diff[ADDR_W];
  end

  // Midpoint of the window [lo, end) and of both halves it may shrink to.
  always_comb begin
    sum_mid = (CW+1)'(lo_q) + (CW+1)'(end_q) - (CW+1)'(1);
    mid     = sum_mid[CW:1];
    sum_a   = (CW+1)'(mid) + (CW+1)'(end_q);
    sum_b   = (CW+1)'(lo_q) + (CW+1)'(mid) - (CW+1)'(1);
    mid_a   = sum_a[CW:1];
    mid_b   = sum_b[CW:1];
  end

  // Narrowed window and updated match for the next cell.
  always_comb begin
    nxt_lo_o  = hit ? (mid + CW'(1)) : lo_q;
    nxt_end_o = hit ? end_q : mid;
    nxt_idx_o = hit ? mid[AW-1:0] : idx_q;
    new_empty = (nxt_lo_o >= nxt_end_o);

    nxt_tok_o.valid      = valid_q && !new_empty;
    nxt_tok_o.sel_a      = hit;
    nxt_tok_o.hit.found  = found_q | hit;
    nxt_tok_o.hit.offset = hit ? diff[ADDR_W-1:0] : off_q;
  end

  assign active_o  = valid_q;
  assign done_o    = valid_q && new_empty;
  assign raddr_a_o = mid_a[AW-1:0];
  assign raddr_b_o = mid_b[AW-1:0];

endmodule

>>> hw/rtl/sorted_address_floor_search_unit.sv
// Each lookup walks the chain of search cells, one cell per halving of the
// window; the number of halvings is at most ceil(log2(TABLE_DEPTH + 1)) (11
// for 1024 entries), and a lookup with a zero count skips the chain. Both
// candidate probes of the next cell are read ahead. A new command, write or
// lookup, is accepted only while no search runs and the result stage is empty.
// Reset clears the count register and all handshake state; the table is kept.
// ----------------------------------------------------------------------------
// Sorted address floor search unit
// Keeps a table of ascending start addresses and finds, for a query, the
// last entry at or below it together with the distance from that entry.
// ----------------------------------------------------------------------------
module sorted_address_floor_search_unit
  import sfs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sfs_in_if.sink   in_i,
  sfs_out_if.source out_o,
  sfs_cfg_if.sink  cfg_i
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NCELL = CW;
  localparam int unsigned XW    = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned KW    = (CW > CNT_W) ? CW : CNT_W;

  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] query_q;

  logic              in_acc;
  logic              lookup_acc;
  logic              write_acc;
  logic [XW:0]       widx_x;
  logic              wr_in_range;
  logic [KW-1:0]     cnt_x;
  logic [CW-1:0]     cnt_sat;
  logic [CW:0]       sum0;
  logic [CW-1:0]     mid0;
  logic              zero_lookup;

  sfs_tok_t          start_tok;
  sfs_tok_t          tok_nxt  [NCELL];
  logic [CW-1:0]     lo_nxt   [NCELL];
  logic [CW-1:0]     end_nxt  [NCELL];
  logic [AW-1:0]     idx_nxt  [NCELL];
  logic [AW-1:0]     cell_ra  [NCELL];
  logic [AW-1:0]     cell_rb  [NCELL];
  logic [NCELL-1:0]  cell_act;
  logic [NCELL-1:0]  cell_done;

  logic [AW-1:0]     raddr_a;
  logic [AW-1:0]     raddr_b;
  logic [ADDR_W-1:0] rdata_a;
  logic [ADDR_W-1:0] rdata_b;
  logic              busy;

  sfs_hit_t          done_hit;
  logic [AW-1:0]     done_idx;
  logic [XW-1:0]     done_idx_x;

  logic              res_valid_q;
  logic              res_valid_d;
  sfs_hit_t          res_hit_q;
  sfs_hit_t          res_hit_d;
  logic [IDX_W-1:0]  res_idx_q;
  logic [IDX_W-1:0]  res_idx_d;
  logic              res_load;
  logic              res_move;

  logic              out_valid_q;
  logic              out_valid_d;
  sfs_hit_t          out_hit_q;
  logic [IDX_W-1:0]  out_idx_q;

  // Input decode. A write beyond the table is dropped.
  always_comb begin
    in_acc      = in_i.valid && in_i.ready;
    lookup_acc  = in_acc && (in_i.command == CMD_LOOKUP);
    write_acc   = in_acc && (in_i.command == CMD_WRITE);
    widx_x      = (XW+1)'(in_i.entry_index);
    wr_in_range = (widx_x < (XW+1)'(TABLE_DEPTH));
  end

  // Count register, saturated to the table depth for the search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      count_q <= cfg_i.symbol_count;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cnt_x       = KW'(count_q);
    cnt_sat     = (cnt_x > KW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_x[CW-1:0];
    sum0        = (CW+1)'(cnt_sat) - (CW+1)'(1);
    mid0        = sum0[CW:1];
    zero_lookup = lookup_acc && (cnt_sat == '0);
  end

  // The query stays put while its token walks the chain.
  always_ff @(posedge clk_i) begin
    if (lookup_acc) begin
      query_q <= in_i.query_address;
    end
  end

  // First token: full window, probe of its midpoint on read port A.
  always_comb begin
    start_tok.valid      = lookup_acc && (cnt_sat != '0);
    start_tok.sel_a      = 1'b1;
    start_tok.hit.found  = 1'b0;
    start_tok.hit.offset = '0;
  end

  // Chain of search cells, one halving of the window per cell.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == 0) begin : g_first
      sfs_cell #(
        .AW (AW),
        .CW (CW)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .prev_tok_i (start_tok),
        .prev_lo_i  ('0),
        .prev_end_i (cnt_sat),
        .prev_idx_i ('0),
        .query_i    (query_q),
        .rdata_a_i  (rdata_a),
        .rdata_b_i  (rdata_b),
        .nxt_tok_o  (tok_nxt[k]),
        .nxt_lo_o   (lo_nxt[k]),
        .nxt_end_o  (end_nxt[k]),
        .nxt_idx_o  (idx_nxt[k]),
        .active_o   (cell_act[k]),
        .done_o     (cell_done[k]),
        .raddr_a_o  (cell_ra[k]),
        .raddr_b_o  (cell_rb[k])
      );
    end else begin : g_rest
      sfs_cell #(
        .AW (AW),
        .CW (CW)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .prev_tok_i (tok_nxt[k-1]),
        .prev_lo_i  (lo_nxt[k-1]),
        .prev_end_i (end_nxt[k-1]),
        .prev_idx_i (idx_nxt[k-1]),
        .query_i    (query_q),
        .rdata_a_i  (rdata_a),
        .rdata_b_i  (rdata_b),
        .nxt_tok_o  (tok_nxt[k]),
        .nxt_lo_o   (lo_nxt[k]),
        .nxt_end_o  (end_nxt[k]),
        .nxt_idx_o  (idx_nxt[k]),
        .active_o   (cell_act[k]),
        .done_o     (cell_done[k]),
        .raddr_a_o  (cell_ra[k]),
        .raddr_b_o  (cell_rb[k])
      );
    end
  end

  assign busy = (|cell_act) || res_valid_q;

  // Read addresses come from the one active cell, or from the start probe.
  always_comb begin
    raddr_a = busy ? '0 : mid0[AW-1:0];
    raddr_b = '0;
    for (int k = 0; k < NCELL; k++) begin
      if (cell_act[k]) begin
        raddr_a = raddr_a | cell_ra[k];
        raddr_b = raddr_b | cell_rb[k];
      end
    end
  end

  sfs_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (write_acc && wr_in_range),
    .waddr_i   (widx_x[AW-1:0]),
    .wdata_i   (in_i.entry_address),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Collect the match of the cell whose window just ran empty.
  always_comb begin
    done_hit = '0;
    done_idx = '0;
    for (int k = 0; k < NCELL; k++) begin
      if (cell_done[k]) begin
        done_hit = done_hit | tok_nxt[k].hit;
        done_idx = done_idx | idx_nxt[k];
      end
    end
    done_idx_x = XW'(done_idx);
  end

  // Result stage: holds a finished word until the output register is free.
  always_comb begin
    res_load    = (|cell_done) || zero_lookup;
    res_move    = res_valid_q && (!out_valid_q || out_o.ready);
    res_hit_d   = done_hit;
    res_idx_d   = done_idx_x[IDX_W-1:0];
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_move) begin
      res_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (res_move) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_hit_q <= res_hit_d;
      res_idx_q <= res_idx_d;
    end
    if (res_move) begin
      out_hit_q <= res_hit_q;
      out_idx_q <= res_idx_q;
    end
  end

  // Ports.
  assign in_i.ready         = !busy;
  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_hit_q.found;
  assign out_o.symbol_index = out_idx_q;
  assign out_o.offset       = out_hit_q.offset;

  // Only one lookup is in flight, so at most one cell holds a token.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_act))
    else $error("more than one search cell is active");

  // The chain is long enough that the last cell always finishes the search.
  a_chain_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tok_nxt[NCELL-1].valid)
    else $error("search token ran off the end of the cell chain");

  // No search runs while a finished word waits in the result stage.
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (cell_act == '0))
    else $error("search active while a result is pending");

  // A lookup over an empty table finishes at once.
  a_zero_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_lookup |=> res_valid_q)
    else $error("empty lookup did not finish in one cycle");

  // A miss reports index and offset of zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |-> (out_o.offset == '0 && out_o.symbol_index == '0))
    else $error("miss word carries a nonzero index or offset");

endmodule
